FILE: src/triangle_orbit_position_core_defines.svh
// Assertion helpers shared by the orbit position core
`ifndef TRIANGLE_ORBIT_POSITION_CORE_DEFINES_SVH
`define TRIANGLE_ORBIT_POSITION_CORE_DEFINES_SVH

// checked only while out of reset
`define TORB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TORB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/torb_pkg.sv
package torb_pkg;

	// number formats
	localparam int ANGLE_BITS = 32;
	localparam int FRAC_BITS  = 32;
	localparam int TRIG_FRAC  = FRAC_BITS + 2;
	localparam int CORD_FRAC  = FRAC_BITS + 8;
	localparam int CORD_ITER  = FRAC_BITS + 6;
	localparam int IDXW       = $clog2(CORD_ITER);
	localparam int CW         = CORD_FRAC + 3;
	localparam int ZW         = ANGLE_BITS + 1;
	localparam int TW         = TRIG_FRAC + 2;
	localparam int NLANE      = 6;

	// field widths
	localparam int POS_W  = 48;
	localparam int ECC_W  = 32;
	localparam int RAD_W  = 8;
	localparam int FREQ_W = 8;
	localparam int PH_W   = 32;
	localparam int TIME_W = 48;
	localparam int CIDX_W = 2;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// post-processing widths
	localparam int LW1 = TW + 3;
	localparam int LW2 = TW + 5;
	localparam int AW  = TW + 6;
	localparam int ZB  = TW + 2;
	localparam int IW  = TW + 3;
	localparam int FW  = AW + RAD_W + 1;
	localparam int TRIG_SH = CORD_FRAC - TRIG_FRAC;
	localparam int OUT_SH  = TRIG_FRAC - FRAC_BITS;

	// lanes of the rotation row
	localparam int LANE_A = 0;
	localparam int LANE_B = 1;
	localparam int LANE_P = 2;
	localparam int LANE_Q = 3;
	localparam int LANE_R = 4;
	localparam int LANE_D = 5;

	// two input-register stages, the rotation row, seven post stages
	localparam int LATENCY = 2 + CORD_ITER + 7;

	localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;
	localparam logic [32:0] SQRT3_Q32    = 33'd7439101574;
	localparam logic [ANGLE_BITS-1:0] THIRD =
		ANGLE_BITS'(((65'd1 << ANGLE_BITS) + 65'd1) / 65'd3);
	localparam logic signed [ZB-1:0] TRIG_ONE = ZB'(65'd1 << TRIG_FRAC);

	// register reset values
	localparam logic [RAD_W-1:0]  RESET_RADIUS = 8'd1;
	localparam logic [ECC_W-1:0]  RESET_ECC    = 32'd41446434;
	localparam logic [FREQ_W-1:0] RESET_FREQ   = 8'd1;
	localparam logic [ECC_W-1:0]  RESET_ECC_SQ =
		ECC_W'((64'(RESET_ECC) * 64'(RESET_ECC)) >> 32);

	typedef enum logic [CFG_AW-1:0] {
		REG_RADIUS,
		REG_ECC,
		REG_FREQ,
		REG_LONG,
		REG_ORIENT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		quad_t                quad;
	} lane_t;

	typedef struct packed {
		logic                    valid;
		lane_t [NLANE-1:0]       lane;
	} stage_t;

	typedef struct packed {
		logic [ECC_W-1:0] ecc;
		logic [ECC_W-1:0] ecc_sq;
		logic [RAD_W-1:0] radius;
	} coef_t;

	typedef logic signed [ZW-1:0] atan_tab_t [CORD_ITER];

	// restoring division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in turns, series in 2.62 fixed point
	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0]  sum;
		logic [63:0]  term;
		logic [63:0]  t64;
		logic [127:0] p;
		int           ex;
		sum = '0;
		if (i == 0)
			return 64'd1 << (ANGLE_BITS - 3);
		for (int k = 0; k < 32; k++) begin
			ex = i * (2 * k + 1);
			if (ex <= 62) begin
				term = udiv64(64'd1 << (62 - ex), 64'(2 * k + 1));
				if (k[0])
					sum = sum - term;
				else
					sum = sum + term;
			end
		end
		p = {64'd0, sum} * {64'd0, TURN_PER_RAD};
		t64 = p[125:62];
		return (t64 + (64'd1 << (63 - ANGLE_BITS))) >> (64 - ANGLE_BITS);
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t t;
		for (int i = 0; i < CORD_ITER; i++)
			t[i] = ZW'(atan_entry(i));
		return t;
	endfunction

	// start vector: reciprocal of the rotation gain seen along x at zero angle
	function automatic logic [CW-1:0] build_k();
		logic signed [63:0] gx;
		logic signed [63:0] gy;
		logic signed [63:0] gz;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		logic [63:0]        g;
		logic [63:0]        r;
		logic [63:0]        q;
		gx = 64'sd1 <<< 60;
		gy = '0;
		gz = '0;
		for (int i = 0; i < CORD_ITER; i++) begin
			xs = gx >>> i;
			ys = gy >>> i;
			if (!gz[63]) begin
				gx = gx - ys;
				gy = gy + xs;
				gz = gz - $signed(atan_entry(i));
			end else begin
				gx = gx + ys;
				gy = gy - xs;
				gz = gz + $signed(atan_entry(i));
			end
		end
		g = gx;
		r = 64'd1 << 60;
		q = '0;
		for (int b = 0; b < CORD_FRAC; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= g) begin
				r = r - g;
				q[0] = 1'b1;
			end
		end
		return CW'(q);
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();
	localparam logic signed [CW-1:0] CORD_K = build_k();

	// 32-bit phase to angle format, top bits kept
	function automatic logic [ANGLE_BITS-1:0] to_ang(input logic [31:0] v);
		logic [63:0] w;
		w = ({32'd0, v} << 16) >> (48 - ANGLE_BITS);
		return ANGLE_BITS'(w);
	endfunction

	// octant-centered quadrant and residual angle, rotation start vector
	function automatic lane_t reduce_angle(input logic [ANGLE_BITS-1:0] ang);
		logic [ANGLE_BITS-1:0] sh;
		logic [1:0]            q;
		logic [ANGLE_BITS-1:0] d;
		lane_t                 ln;
		sh = ang + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
		q = sh[ANGLE_BITS-1 -: 2];
		d = ang - {q, {(ANGLE_BITS-2){1'b0}}};
		ln.x = CORD_K;
		ln.y = '0;
		ln.z = ZW'($signed(d));
		ln.quad = quad_t'(q);
		return ln;
	endfunction

	// clamp to the signed output range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [FW-1:0] v);
		logic signed [FW-1:0] hi;
		logic signed [FW-1:0] lo;
		hi = $signed({{(FW-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
		lo = -hi - FW'(1);
		if (v > hi)
			return POS_W'(hi);
		else if (v < lo)
			return POS_W'(lo);
		return POS_W'(v);
	endfunction

endpackage

FILE: src/torb_cordic_cell.sv
module torb_cordic_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  torb_pkg::stage_t                in_s,
	input  logic [torb_pkg::IDXW-1:0]       step,
	input  logic signed [torb_pkg::ZW-1:0]  atan_step,
	output torb_pkg::stage_t                out_s
);
	import torb_pkg::*;

	lane_t [NLANE-1:0] lane_d;
	lane_t [NLANE-1:0] lane_q;
	logic              valid_q;

	// one micro-rotation on every lane
	always_comb begin
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		lane_d = in_s.lane;
		for (int l = 0; l < NLANE; l++) begin
			xs = in_s.lane[l].x >>> step;
			ys = in_s.lane[l].y >>> step;
			if (!in_s.lane[l].z[ZW-1]) begin
				lane_d[l].x = in_s.lane[l].x - ys;
				lane_d[l].y = in_s.lane[l].y + xs;
				lane_d[l].z = in_s.lane[l].z - atan_step;
			end else begin
				lane_d[l].x = in_s.lane[l].x + ys;
				lane_d[l].y = in_s.lane[l].y - xs;
				lane_d[l].z = in_s.lane[l].z + atan_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= in_s.valid;
	end

	always_ff @(posedge clk) begin
		lane_q <= lane_d;
	end

	always_comb begin
		out_s.valid = valid_q;
		out_s.lane  = lane_q;
	end

endmodule

FILE: src/torb_cordic_chain.sv
module torb_cordic_chain (
	input  logic              clk,
	input  logic              arst_n,
	input  torb_pkg::stage_t  in_s,
	output torb_pkg::stage_t  out_s
);
	import torb_pkg::*;

	stage_t link [CORD_ITER+1];

	assign link[0] = in_s;

	// one cell per rotation step
	for (genvar k = 0; k < CORD_ITER; k++) begin : g_cell
		torb_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_s      (link[k]),
			.step      (IDXW'(k)),
			.atan_step (ATAN_TAB[k]),
			.out_s     (link[k+1])
		);
	end

	assign out_s = link[CORD_ITER];

endmodule

FILE: src/torb_combine.sv
module torb_combine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  torb_pkg::stage_t                  in_s,
	input  torb_pkg::coef_t                   coef,
	output logic                              done,
	output logic signed [torb_pkg::POS_W-1:0] pos_x,
	output logic signed [torb_pkg::POS_W-1:0] pos_y,
	output logic signed [torb_pkg::POS_W-1:0] pos_z
);
	import torb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [TW-1:0]  c_s1 [NLANE];
	logic signed [TW-1:0]  s_s1 [NLANE];

	logic signed [LW1-1:0] px_s2, py_s2;
	logic signed [LW2-1:0] qx_s2, qy_s2;
	logic signed [TW-1:0]  ca_s2, sa_s2, cd_s2, sd_s2;
	logic [TW-1:0]         absd_s2;

	logic signed [AW-1:0]  mx1_s3, mx2_s3, my1_s3, my2_s3;
	logic signed [TW-1:0]  ca_s3, sa_s3, sq2_s3, cde_s3;

	logic signed [AW-1:0]  accx_s4, accy_s4;
	logic signed [ZB-1:0]  zp_s4;
	logic signed [TW-1:0]  cde_s4;

	logic signed [AW-1:0]  accx_s5, accy_s5;
	logic signed [IW-1:0]  inner_s5;

	logic signed [AW-1:0]  accx_s6, accy_s6, accz_s6;

	logic signed [POS_W-1:0] px_s7, py_s7, pz_s7;

	// control: valid through the post stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_s.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// s1: round down to trig format, fold back the quadrant
	always_ff @(posedge clk) begin
		for (int l = 0; l < NLANE; l++) begin
			unique case (in_s.lane[l].quad)
				QUAD_0: begin
					c_s1[l] <= TW'(in_s.lane[l].x >>> TRIG_SH);
					s_s1[l] <= TW'(in_s.lane[l].y >>> TRIG_SH);
				end
				QUAD_1: begin
					c_s1[l] <= -TW'(in_s.lane[l].y >>> TRIG_SH);
					s_s1[l] <= TW'(in_s.lane[l].x >>> TRIG_SH);
				end
				QUAD_2: begin
					c_s1[l] <= -TW'(in_s.lane[l].x >>> TRIG_SH);
					s_s1[l] <= -TW'(in_s.lane[l].y >>> TRIG_SH);
				end
				QUAD_3: begin
					c_s1[l] <= TW'(in_s.lane[l].y >>> TRIG_SH);
					s_s1[l] <= -TW'(in_s.lane[l].x >>> TRIG_SH);
				end
				default: begin
					c_s1[l] <= '0;
					s_s1[l] <= '0;
				end
			endcase
		end
	end

	// s2: linear combinations of the harmonics
	always_ff @(posedge clk) begin
		px_s2 <= LW1'(c_s1[LANE_P]) - (LW1'(c_s1[LANE_B]) <<< 1) - LW1'(c_s1[LANE_B]);
		py_s2 <= LW1'(s_s1[LANE_P]) - (LW1'(s_s1[LANE_B]) <<< 1) - LW1'(s_s1[LANE_B]);
		qx_s2 <= (LW2'(c_s1[LANE_Q]) <<< 1) + LW2'(c_s1[LANE_Q])
			- (LW2'(c_s1[LANE_A]) <<< 3) - (LW2'(c_s1[LANE_A]) <<< 1)
			- (LW2'(c_s1[LANE_R]) <<< 2) - LW2'(c_s1[LANE_R]);
		qy_s2 <= (LW2'(s_s1[LANE_Q]) <<< 1) + LW2'(s_s1[LANE_Q])
			- (LW2'(s_s1[LANE_A]) <<< 3) - (LW2'(s_s1[LANE_A]) <<< 1)
			+ (LW2'(s_s1[LANE_R]) <<< 2) + LW2'(s_s1[LANE_R]);
		ca_s2   <= c_s1[LANE_A];
		sa_s2   <= s_s1[LANE_A];
		cd_s2   <= c_s1[LANE_D];
		sd_s2   <= s_s1[LANE_D];
		absd_s2 <= s_s1[LANE_D][TW-1] ? TW'(-s_s1[LANE_D]) : TW'(s_s1[LANE_D]);
	end

	// s3: products with e, e^2 and the squared sine
	logic signed [LW1+33-1:0] prx, pry;
	logic signed [LW2+33-1:0] prqx, prqy;
	logic signed [2*TW:0]     prsq;
	logic signed [TW+33-1:0]  prcd;

	always_comb begin
		prx  = (LW1+33)'(px_s2) * (LW1+33)'($signed({1'b0, coef.ecc}));
		pry  = (LW1+33)'(py_s2) * (LW1+33)'($signed({1'b0, coef.ecc}));
		prqx = (LW2+33)'(qx_s2) * (LW2+33)'($signed({1'b0, coef.ecc_sq}));
		prqy = (LW2+33)'(qy_s2) * (LW2+33)'($signed({1'b0, coef.ecc_sq}));
		prsq = (2*TW+1)'(sd_s2) * (2*TW+1)'($signed({1'b0, absd_s2}));
		prcd = (TW+33)'(cd_s2) * (TW+33)'($signed({1'b0, coef.ecc}));
	end

	always_ff @(posedge clk) begin
		mx1_s3 <= AW'(prx >>> 33);
		my1_s3 <= AW'(pry >>> 33);
		mx2_s3 <= AW'(prqx >>> 35);
		my2_s3 <= AW'(prqy >>> 35);
		sq2_s3 <= TW'(prsq >>> TRIG_FRAC);
		cde_s3 <= TW'(prcd >>> 32);
		ca_s3  <= ca_s2;
		sa_s3  <= sa_s2;
	end

	// s4: planar sums, e^2 term of z
	logic signed [ZB-1:0]    zbase;
	logic signed [ZB+33-1:0] przp;

	always_comb begin
		zbase = ZB'(sq2_s3) + TRIG_ONE;
		przp  = (ZB+33)'(zbase) * (ZB+33)'($signed({1'b0, coef.ecc_sq}));
	end

	always_ff @(posedge clk) begin
		accx_s4 <= AW'(ca_s3) + mx1_s3 + mx2_s3;
		accy_s4 <= AW'(sa_s3) + my1_s3 + my2_s3;
		zp_s4   <= ZB'(przp >>> 32);
		cde_s4  <= cde_s3;
	end

	// s5: z bracket
	always_ff @(posedge clk) begin
		inner_s5 <= IW'(zp_s4) - IW'(cde_s4);
		accx_s5  <= accx_s4;
		accy_s5  <= accy_s4;
	end

	// s6: scale z by sqrt3
	logic signed [IW+34-1:0] prz;

	always_comb begin
		prz = (IW+34)'(inner_s5) * (IW+34)'($signed({1'b0, SQRT3_Q32}));
	end

	always_ff @(posedge clk) begin
		accz_s6 <= AW'(prz >>> 32);
		accx_s6 <= accx_s5;
		accy_s6 <= accy_s5;
	end

	// s7: radius, drop to output format, clamp
	logic signed [FW-1:0] rx, ry, rz;

	always_comb begin
		rx = (FW'(accx_s6) * FW'($signed({1'b0, coef.radius}))) >>> OUT_SH;
		ry = (FW'(accy_s6) * FW'($signed({1'b0, coef.radius}))) >>> OUT_SH;
		rz = (FW'(accz_s6) * FW'($signed({1'b0, coef.radius}))) >>> OUT_SH;
	end

	always_ff @(posedge clk) begin
		px_s7 <= sat_pos(rx);
		py_s7 <= sat_pos(ry);
		pz_s7 <= sat_pos(rz);
	end

	assign done  = v_s7;
	assign pos_x = px_s7;
	assign pos_y = py_s7;
	assign pos_z = pz_s7;

endmodule

FILE: src/triangle_orbit_position_core.sv
// Orbit position core: takes one request (time, craft index) per clock whenever start is high;
// busy is always low. Each result appears on pos_x/pos_y/pos_z for exactly one cycle with
// done high, after its request has passed two input stages, a row of 38 CORDIC cells that
// computes all six sines and cosines side by side, and seven post-processing stages; results
// come out in request order and cannot be held off, so the receiver must take every done
// pulse. Write the configuration registers only while no request is in flight.
`include "triangle_orbit_position_core_defines.svh"

module triangle_orbit_position_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [torb_pkg::TIME_W-1:0]        time_years,
	input  logic [torb_pkg::CIDX_W-1:0]        craft_index,
	input  logic                               cfg_we,
	input  logic [torb_pkg::CFG_AW-1:0]        cfg_index,
	input  logic [torb_pkg::CFG_DW-1:0]        cfg_data,
	output logic                               done,
	output logic signed [torb_pkg::POS_W-1:0]  pos_x,
	output logic signed [torb_pkg::POS_W-1:0]  pos_y,
	output logic signed [torb_pkg::POS_W-1:0]  pos_z
);
	import torb_pkg::*;

	logic [RAD_W-1:0]  radius_q;
	logic [ECC_W-1:0]  ecc_q;
	logic [ECC_W-1:0]  ecc_sq_q;
	logic [FREQ_W-1:0] freq_q;
	logic [PH_W-1:0]   long_q;
	logic [PH_W-1:0]   orient_q;

	logic                  v_s1;
	logic                  v_s2;
	logic [ANGLE_BITS-1:0] a_s1, b_s1;
	lane_t [NLANE-1:0]     lane_s2;
	stage_t                chain_in_s2;
	stage_t                chain_out;
	coef_t                 coef;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RESET_RADIUS;
			ecc_q    <= RESET_ECC;
			freq_q   <= RESET_FREQ;
			long_q   <= '0;
			orient_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				REG_ECC:    ecc_q    <= cfg_data[ECC_W-1:0];
				REG_FREQ:   freq_q   <= cfg_data[FREQ_W-1:0];
				REG_LONG:   long_q   <= cfg_data[PH_W-1:0];
				REG_ORIENT: orient_q <= cfg_data[PH_W-1:0];
				default: ;
			endcase
		end
	end

	// e^2 is registered from e, so it follows e in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ecc_sq_q <= RESET_ECC_SQ;
		else
			ecc_sq_q <= ECC_W'((64'(ecc_q) * 64'(ecc_q)) >> 32);
	end

	// control: request valid into the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	// s1: orbital and craft phases
	logic [31:0] ft_lo;

	always_comb begin
		ft_lo = 32'(32'(freq_q) * time_years[31:0]) + orient_q;
	end

	always_ff @(posedge clk) begin
		a_s1 <= to_ang(ft_lo);
		b_s1 <= ANGLE_BITS'(64'(craft_index) * 64'(THIRD)) + to_ang(long_q);
	end

	// s2: the six angles, reduced to a quadrant and residual
	always_ff @(posedge clk) begin
		lane_s2[LANE_A] <= reduce_angle(a_s1);
		lane_s2[LANE_B] <= reduce_angle(b_s1);
		lane_s2[LANE_P] <= reduce_angle((a_s1 << 1) - b_s1);
		lane_s2[LANE_Q] <= reduce_angle((a_s1 << 1) + a_s1 - (b_s1 << 1));
		lane_s2[LANE_R] <= reduce_angle(a_s1 - (b_s1 << 1));
		lane_s2[LANE_D] <= reduce_angle(a_s1 - b_s1);
	end

	always_comb begin
		chain_in_s2.valid = v_s2;
		chain_in_s2.lane  = lane_s2;
	end

	torb_cordic_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s   (chain_in_s2),
		.out_s  (chain_out)
	);

	always_comb begin
		coef.ecc    = ecc_q;
		coef.ecc_sq = ecc_sq_q;
		coef.radius = radius_q;
	end

	torb_combine u_combine (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s   (chain_out),
		.coef   (coef),
		.done   (done),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z)
	);

	// every request yields a result after the fixed latency, and only then
	`TORB_ASSERT(a_req_to_done, (start |-> ##LATENCY done), "request without result")
	`TORB_ASSERT(a_done_from_req, (done |-> $past(start, LATENCY)), "result without request")
	`TORB_ASSERT_ALWAYS(a_no_done_in_reset, (!$past(arst_n) |-> !done), "result during reset")

endmodule
